// ===== rtl/core/stpg_pkg.sv =====
// ----------------------------------------------------------------------------
// Stepper trapezoid pulse generator package
// Shared types and constants: move phase, command kinds, register indexes,
// reset values and the packed result beat.
// ----------------------------------------------------------------------------
package stpg_pkg;

    // Move phase of the trapezoid profile.
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_UP     = 2'd1,
        PH_CRUISE = 2'd2,
        PH_DOWN   = 2'd3
    } phase_t;

    // Input beat kinds carried on tuser.
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_MOVE = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_CRUISE = 1'b0;
    localparam logic CFG_START  = 1'b1;

    // Register reset values.
    localparam logic [15:0] CRUISE_RESET = 16'h0444;
    localparam logic [15:0] START_RESET  = 16'd4000;

    // Shortest move that is carried out.
    localparam logic [15:0] MIN_STEPS = 16'd2;

    // floor(s / 3) == (s * RECIP3) >> RECIP3_SHIFT for every 16-bit s.
    localparam logic [31:0] RECIP3       = 32'd43691;
    localparam int          RECIP3_SHIFT = 17;

    // Result beat, lowest bit last in the declaration.
    typedef struct packed {
        logic       rejected;
        logic       move_done;
        logic [7:0] shaft_position;
        logic       busy_res;
        logic       dir_level;
        logic       step_level;
    } result_t;

endpackage

// ===== rtl/core/stepper_trapezoid_pulse_generator_core.sv =====
// ----------------------------------------------------------------------------
// Stepper trapezoid pulse generator core
// Runs a trapezoidal move (ramp up, cruise, ramp down) one tick beat at a time
// and reports step and direction levels, busy, position and move status.
// ----------------------------------------------------------------------------
// The result of a beat is registered into the output stage, then shown on the master side.
// Throughput: one beat per cycle while the skid register is empty; the state update is a single registered pass.
// A two-entry output stage lets input beats keep flowing while a result waits.
// The move remainder (steps modulo steps per revolution) passes through the quotient
// and remainder registers after a command, well before the shortest move can end.
// Reset (rst_n low, asynchronous) returns the registers and the move state to
// their defaults and empties the output stage.
module stepper_trapezoid_pulse_generator_core #(
    parameter int STEPS_PER_REV = 200
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // steps[15:0], clockwise[16], accel_limit[24:17]
    input  logic        s_tuser,   // kind[0]
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // step_level[0], dir_level[1], busy_res[2],
                                   // shaft_position[10:3], move_done[11], rejected[12]
    // Configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata
);
    import stpg_pkg::*;

    localparam int          PW           = $clog2(STEPS_PER_REV);
    localparam int          REV_SHIFT    = 17;
    localparam logic [31:0] REV_RECIP    = 32'((1 << REV_SHIFT) / STEPS_PER_REV);
    localparam logic [31:0] REV_N32      = 32'(STEPS_PER_REV);
    localparam logic [PW:0] REV_N        = (PW + 1)'(STEPS_PER_REV);

    // Input beat fields.
    logic        in_kind;
    logic [15:0] in_steps;
    logic        in_clockwise;
    logic [7:0]  in_accel_limit;
    logic        accept;

    assign in_kind        = s_tuser;
    assign in_steps       = s_tdata[15:0];
    assign in_clockwise   = s_tdata[16];
    assign in_accel_limit = s_tdata[24:17];

    // Configuration registers.
    logic [15:0] cruise_delay_reg;
    logic [15:0] ramp_start_delay_reg;
    logic [15:0] cfg_value;

    // Move state.
    phase_t        phase_reg, phase_next;
    logic [15:0]   phase_count_reg, phase_count_next;
    logic [15:0]   cruise_count_reg, cruise_count_next;
    logic [15:0]   current_delay_reg, current_delay_next;
    logic [15:0]   half_timer_reg, half_timer_next;
    logic          pulse_high_reg, pulse_high_next;
    logic [PW-1:0] position_reg, position_next;
    logic          moving_clockwise_reg, moving_clockwise_next;
    logic [15:0]   move_length_reg, move_length_next;
    logic [7:0]    ramp_step_reg, ramp_step_next;
    logic [15:0]   ramp_len_reg, ramp_len_next;

    // Move remainder pipeline.
    logic [31:0]   rev_prod;
    logic [14:0]   rev_quot_reg;
    logic [31:0]   rev_back;
    logic [31:0]   rev_rem_raw;
    logic [PW-1:0] rev_rem_reg, rev_rem_next;

    // Per-beat helpers.
    logic [31:0]   div3_prod;
    logic [15:0]   cmd_third;
    logic [15:0]   cmd_ramp;
    logic [16:0]   up_limit;
    logic [16:0]   down_reach;
    logic [15:0]   count_dec;
    logic [PW:0]   pos_cw_sum;
    logic [PW:0]   pos_ccw_sum;
    logic [PW:0]   pos_cw;
    logic [PW:0]   pos_ccw;
    logic [31:0]   pos_wide;
    logic          rej_c;
    logic          done_c;
    result_t       result_c;

    // Output stage: main register plus skid register.
    result_t out_data_reg, skid_data_reg;
    logic    out_valid_reg, skid_valid_reg;
    logic    pop;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_data_reg};

    // A zero write holds one; a cruise write is clamped to the start delay.
    always_comb
    begin
        cfg_value = (cfg_wdata == 16'd0) ? 16'd1 : cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cruise_delay_reg     <= CRUISE_RESET;
            ramp_start_delay_reg <= START_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CRUISE:
                begin
                    cruise_delay_reg <= (cfg_value > ramp_start_delay_reg) ?
                                        ramp_start_delay_reg : cfg_value;
                end
                CFG_START:
                begin
                    ramp_start_delay_reg <= cfg_value;
                end
                default:
                begin
                    cruise_delay_reg <= cruise_delay_reg;
                end
            endcase
        end
    end

    // Remainder of the move length by the steps per revolution: a reciprocal
    // multiply gives a quotient at most one short, fixed by one subtract.
    assign rev_prod    = 32'(move_length_reg) * REV_RECIP;
    assign rev_back    = 32'(rev_quot_reg) * REV_N32;
    assign rev_rem_raw = 32'(move_length_reg) - rev_back;

    always_comb
    begin
        if (rev_rem_raw >= REV_N32)
        begin
            rev_rem_next = PW'(rev_rem_raw - REV_N32);
        end
        else
        begin
            rev_rem_next = PW'(rev_rem_raw);
        end
    end

    always_ff @(posedge clk)
    begin
        rev_quot_reg <= rev_prod[31:REV_SHIFT];
        rev_rem_reg  <= rev_rem_next;
    end

    // Ramp length of a new command: max(1, steps / 3).
    assign div3_prod = 32'(in_steps) * RECIP3;
    assign cmd_third = 16'(div3_prod[31:RECIP3_SHIFT]);
    assign cmd_ramp  = (cmd_third == 16'd0) ? 16'd1 : cmd_third;

    // Delay ramp limits, one bit wider so that nothing wraps.
    assign up_limit   = {1'b0, cruise_delay_reg} + 17'(ramp_step_reg);
    assign down_reach = {1'b0, current_delay_reg} + 17'(ramp_step_reg);
    assign count_dec  = (phase_count_reg != 16'd0) ? phase_count_reg - 16'd1 : phase_count_reg;

    // Position after the move, wrapped into one revolution.
    assign pos_cw_sum  = {1'b0, position_reg} + {1'b0, rev_rem_reg};
    assign pos_ccw_sum = {1'b0, position_reg} + (REV_N - {1'b0, rev_rem_reg});
    assign pos_cw      = (pos_cw_sum >= REV_N) ? pos_cw_sum - REV_N : pos_cw_sum;
    assign pos_ccw     = (pos_ccw_sum >= REV_N) ? pos_ccw_sum - REV_N : pos_ccw_sum;

    // Next move state for the accepted beat.
    always_comb
    begin
        phase_next            = phase_reg;
        phase_count_next      = phase_count_reg;
        cruise_count_next     = cruise_count_reg;
        current_delay_next    = current_delay_reg;
        half_timer_next       = half_timer_reg;
        pulse_high_next       = pulse_high_reg;
        position_next         = position_reg;
        moving_clockwise_next = moving_clockwise_reg;
        move_length_next      = move_length_reg;
        ramp_step_next        = ramp_step_reg;
        ramp_len_next         = ramp_len_reg;
        rej_c                 = 1'b0;
        done_c                = 1'b0;

        if (accept)
        begin
            if (in_kind == KIND_MOVE)
            begin
                if (phase_reg != PH_IDLE || in_steps < MIN_STEPS)
                begin
                    rej_c = 1'b1;
                end
                else
                begin
                    move_length_next      = in_steps;
                    moving_clockwise_next = in_clockwise;
                    ramp_step_next        = in_accel_limit;
                    ramp_len_next         = cmd_ramp;
                    cruise_count_next     = in_steps - {cmd_ramp[14:0], 1'b0};
                    phase_next            = PH_UP;
                    phase_count_next      = cmd_ramp;
                    current_delay_next    = ramp_start_delay_reg;
                    half_timer_next       = 16'd1;
                    pulse_high_next       = 1'b1;
                end
            end
            else if (phase_reg != PH_IDLE)
            begin
                if (half_timer_reg >= current_delay_reg)
                begin
                    half_timer_next = 16'd1;
                    if (pulse_high_reg)
                    begin
                        pulse_high_next = 1'b0;
                    end
                    else
                    begin
                        // A full pulse has ended: step the delay along the ramp.
                        if (phase_reg == PH_UP)
                        begin
                            if ({1'b0, current_delay_reg} > up_limit)
                            begin
                                current_delay_next = current_delay_reg - 16'(ramp_step_reg);
                            end
                            else
                            begin
                                current_delay_next = cruise_delay_reg;
                            end
                        end
                        else if (phase_reg == PH_DOWN)
                        begin
                            if (down_reach < {1'b0, ramp_start_delay_reg})
                            begin
                                current_delay_next = 16'(down_reach);
                            end
                            else
                            begin
                                current_delay_next = ramp_start_delay_reg;
                            end
                        end

                        // Count the pulse and move on when the phase runs out.
                        phase_count_next = count_dec;
                        pulse_high_next  = 1'b1;
                        if (count_dec == 16'd0)
                        begin
                            unique case (phase_reg)
                                PH_UP:
                                begin
                                    if (cruise_count_reg != 16'd0)
                                    begin
                                        phase_next       = PH_CRUISE;
                                        phase_count_next = cruise_count_reg;
                                    end
                                    else
                                    begin
                                        phase_next       = PH_DOWN;
                                        phase_count_next = ramp_len_reg;
                                    end
                                end
                                PH_CRUISE:
                                begin
                                    phase_next       = PH_DOWN;
                                    phase_count_next = ramp_len_reg;
                                end
                                default:
                                begin
                                    position_next   = moving_clockwise_reg ?
                                                      pos_cw[PW-1:0] : pos_ccw[PW-1:0];
                                    phase_next      = PH_IDLE;
                                    pulse_high_next = 1'b0;
                                    half_timer_next = 16'd0;
                                    done_c          = 1'b1;
                                end
                            endcase
                        end
                    end
                end
                else
                begin
                    half_timer_next = half_timer_reg + 16'd1;
                end
            end
        end
    end

    // Move state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= PH_IDLE;
            phase_count_reg      <= 16'd0;
            cruise_count_reg     <= 16'd0;
            current_delay_reg    <= START_RESET;
            half_timer_reg       <= 16'd0;
            pulse_high_reg       <= 1'b0;
            position_reg         <= '0;
            moving_clockwise_reg <= 1'b1;
            move_length_reg      <= 16'd0;
            ramp_step_reg        <= 8'd0;
            ramp_len_reg         <= 16'd0;
        end
        else
        begin
            phase_reg            <= phase_next;
            phase_count_reg      <= phase_count_next;
            cruise_count_reg     <= cruise_count_next;
            current_delay_reg    <= current_delay_next;
            half_timer_reg       <= half_timer_next;
            pulse_high_reg       <= pulse_high_next;
            position_reg         <= position_next;
            moving_clockwise_reg <= moving_clockwise_next;
            move_length_reg      <= move_length_next;
            ramp_step_reg        <= ramp_step_next;
            ramp_len_reg         <= ramp_len_next;
        end
    end

    // Result beat shows the state after the item.
    assign pos_wide = 32'(position_next);

    always_comb
    begin
        result_c.step_level     = pulse_high_next;
        result_c.dir_level      = moving_clockwise_next;
        result_c.busy_res       = (phase_next != PH_IDLE);
        result_c.shaft_position = pos_wide[7:0];
        result_c.move_done      = done_c;
        result_c.rejected       = rej_c;
    end

    // Output stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= skid_valid_reg || accept || (out_valid_reg && !pop);
            if (skid_valid_reg)
            begin
                skid_valid_reg <= !pop;
            end
            else
            begin
                skid_valid_reg <= accept && out_valid_reg && !pop;
            end
        end
    end

    // Output stage data.
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : result_c;
        end
        if (accept && out_valid_reg && !pop)
        begin
            skid_data_reg <= result_c;
        end
    end

endmodule
